FILE: rtl/grid_rectangle_space_allocator_core_assert.svh
// Assertion macros for the grid allocator core.
// Used by grid_rectangle_space_allocator_core.sv; needs a clk and arst_n in scope.
`ifndef GRID_RECTANGLE_SPACE_ALLOCATOR_CORE_ASSERT_SVH
`define GRID_RECTANGLE_SPACE_ALLOCATOR_CORE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define GRAS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define GRAS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/gras_pkg.sv
// Shared types and constants of the grid allocator core.
// No dependencies.
`default_nettype none
package gras_pkg;
	localparam int DEF_GRID_W     = 128;
	localparam int DEF_GRID_H     = 128;
	localparam int DEF_MAX_BLOCKS = 16;

	localparam int ACT_W   = 3;
	localparam int COORD_W = 7;
	localparam int SIZE_W  = 8;
	localparam int FLAG_W  = 3;

	localparam int FLAG_ROW_MAJOR = 0;
	localparam int FLAG_L2R       = 1;
	localparam int FLAG_T2B       = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_FIND      = 3'd0,
		ACT_MARK_USED = 3'd1,
		ACT_MARK_FREE = 3'd2,
		ACT_PLACE     = 3'd3,
		ACT_LIFT      = 3'd4,
		ACT_CLR_OCC   = 3'd5,
		ACT_CLR_OVL   = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		OP_USED_NAT,
		OP_FREE_NAT,
		OP_USED_BLK,
		OP_FREE_BLK
	} paint_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PAINT_RD,
		ST_PAINT_WR,
		ST_LIFT_NEXT,
		ST_FIND_RD,
		ST_FIND_ROW,
		ST_FIND_FIT,
		ST_FIND_PICK,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/grid_rectangle_space_allocator_core.sv
// Grid allocator: marks read-modify-write each touched row of a row-wide grid memory;
// find reads one row at a time, updates per-column free runs and, once the window
// height is filled, runs an 8-step width fit on that row; lift frees the block's rows,
// then walks every list entry and re-marks the rows each overlapping block still covers.
// One item at a time: busy is high from acceptance until the done strobe cycle.
// Reset clears the grid instantly through per-row valid bits and empties the block list.
// Depends on gras_pkg and grid_rectangle_space_allocator_core_assert.svh.
`default_nettype none
`include "grid_rectangle_space_allocator_core_assert.svh"
module grid_rectangle_space_allocator_core #(
	parameter int GRID_W     = gras_pkg::DEF_GRID_W,
	parameter int GRID_H     = gras_pkg::DEF_GRID_H,
	parameter int MAX_BLOCKS = gras_pkg::DEF_MAX_BLOCKS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [gras_pkg::ACT_W-1:0]      action,
	input  wire logic [gras_pkg::COORD_W-1:0]    rect_x,
	input  wire logic [gras_pkg::COORD_W-1:0]    rect_y,
	input  wire logic [gras_pkg::SIZE_W-1:0]     rect_w,
	input  wire logic [gras_pkg::SIZE_W-1:0]     rect_h,
	input  wire logic [gras_pkg::SIZE_W-1:0]     area_w,
	input  wire logic [gras_pkg::SIZE_W-1:0]     area_h,
	input  wire logic [gras_pkg::FLAG_W-1:0]     order_flags,
	output logic                                 done,
	output logic                                 ok,
	output logic [gras_pkg::COORD_W-1:0]         found_x,
	output logic [gras_pkg::COORD_W-1:0]         found_y
);
	localparam int CWX = ($clog2(GRID_W + 1) > $clog2(GRID_H + 1)) ?
		$clog2(GRID_W + 1) : $clog2(GRID_H + 1);
	localparam int CW  = (CWX > gras_pkg::SIZE_W + 1) ? CWX : gras_pkg::SIZE_W + 1;
	localparam int YIW = $clog2(GRID_H);
	localparam int HW  = $clog2(GRID_H + 1);
	localparam int JW  = $clog2(MAX_BLOCKS + 1);
	localparam int JIW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int LW  = gras_pkg::SIZE_W + 1;
	localparam int KW  = $clog2(gras_pkg::SIZE_W);
	localparam int RW  = 3 * GRID_W;
	localparam logic [CW-1:0] GW_C = CW'(GRID_W);
	localparam logic [CW-1:0] GH_C = CW'(GRID_H);
	localparam logic [KW-1:0] K_LAST = KW'(gras_pkg::SIZE_W - 1);
	localparam logic [JW-1:0] J_END = JW'(MAX_BLOCKS);

	function automatic logic [CW-1:0] min_c(input logic [CW-1:0] a, input logic [CW-1:0] b);
		min_c = (a < b) ? a : b;
	endfunction

	function automatic logic [CW-1:0] max_c(input logic [CW-1:0] a, input logic [CW-1:0] b);
		max_c = (a > b) ? a : b;
	endfunction

	function automatic logic [GRID_W-1:0] col_mask(input logic [CW-1:0] lo,
		input logic [CW-1:0] hi);
		logic [GRID_W-1:0] ones;
		ones = '1;
		col_mask = (ones << lo) & ~(ones << hi);
	endfunction

	gras_pkg::state_t state_q, state_n;

	// item registers
	gras_pkg::action_t             act_q;
	logic [gras_pkg::COORD_W-1:0]  x_q, y_q;
	logic [gras_pkg::SIZE_W-1:0]   w_q, h_q, aw_q, ah_q;
	logic [gras_pkg::FLAG_W-1:0]   fl_q;

	// grid memory and row valid bits
	logic [RW-1:0]     mem [GRID_H];
	logic [RW-1:0]     rdata_s1;
	logic              occ_vr_s1, ovl_vr_s1;
	logic [GRID_H-1:0] occ_v_q, ovl_v_q;
	logic [YIW-1:0]    raddr;

	// block list
	logic [gras_pkg::COORD_W-1:0] ent_x_q [MAX_BLOCKS];
	logic [gras_pkg::COORD_W-1:0] ent_y_q [MAX_BLOCKS];
	logic [gras_pkg::SIZE_W-1:0]  ent_w_q [MAX_BLOCKS];
	logic [gras_pkg::SIZE_W-1:0]  ent_h_q [MAX_BLOCKS];
	logic [JW-1:0]                j_q;

	// paint sweep
	logic [CW-1:0]        pr_q, pend_q;
	logic [GRID_W-1:0]    pmask_q;
	gras_pkg::paint_op_t  pop_q;

	// find
	logic [CW-1:0]     r_q, rows_left_q, cnt_q, top_q;
	logic [HW-1:0]     run_q [GRID_W];
	logic [GRID_W-1:0] xmask_q, acc_q, pow_q;
	logic [LW-1:0]     l_q;
	logic [KW-1:0]     k_q;

	// result
	logic          res_ok_q;
	logic [CW-1:0] res_x_q, res_y_q;

	// item rectangle clipped to the grid
	logic [CW-1:0] ex, ey, x0, y0, bw, bh;
	logic          find_bad;
	logic [MAX_BLOCKS-1:0] match;
	logic          any_match, slot_free;
	logic [JW-1:0] slot;

	always_comb begin
		ex = min_c(CW'(x_q) + CW'(w_q), GW_C);
		ey = min_c(CW'(y_q) + CW'(h_q), GH_C);
		x0 = min_c(CW'(x_q), ex);
		y0 = min_c(CW'(y_q), ey);
		bw = ex - x0;
		bh = ey - y0;
		find_bad = (aw_q == '0) || (ah_q == '0) || (CW'(aw_q) > bw) || (CW'(ah_q) > bh);
		any_match = 1'b0;
		slot_free = 1'b0;
		slot = '0;
		for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
			match[i] = (ent_w_q[i] != '0) && (ent_x_q[i] == x_q) && (ent_y_q[i] == y_q) &&
				(ent_w_q[i] == w_q) && (ent_h_q[i] == h_q);
			if (ent_w_q[i] == '0) begin
				slot_free = 1'b1;
				slot = JW'(i);
			end
		end
		any_match = |match;
	end

	// overlap of list entry j with the lifted rectangle
	logic [CW-1:0] lx0, lx1, ly0, ly1, cx0, cx1, cy0, cy1;
	logic          lift_hit;
	logic [JIW-1:0] jidx;

	always_comb begin
		jidx = j_q[JIW-1:0];
		lx0 = max_c(CW'(ent_x_q[jidx]), CW'(x_q));
		ly0 = max_c(CW'(ent_y_q[jidx]), CW'(y_q));
		lx1 = min_c(CW'(x_q) + CW'(w_q), CW'(ent_x_q[jidx]) + CW'(ent_w_q[jidx]));
		ly1 = min_c(CW'(y_q) + CW'(h_q), CW'(ent_y_q[jidx]) + CW'(ent_h_q[jidx]));
		lift_hit = (ent_w_q[jidx] != '0) && (lx1 > lx0) && (ly1 > ly0);
		cx1 = min_c(lx1, GW_C);
		cy1 = min_c(ly1, GH_C);
		cx0 = min_c(lx0, cx1);
		cy0 = min_c(ly0, cy1);
	end

	// row read-modify-write
	logic [GRID_W-1:0] occ_r, nat_r, blk_r, occ_w, nat_w, blk_w;

	always_comb begin
		occ_r = occ_vr_s1 ? rdata_s1[GRID_W-1:0] : '0;
		nat_r = ovl_vr_s1 ? rdata_s1[2*GRID_W-1:GRID_W] : '0;
		blk_r = ovl_vr_s1 ? rdata_s1[RW-1:2*GRID_W] : '0;
		occ_w = occ_r;
		nat_w = nat_r;
		blk_w = blk_r;
		case (pop_q)
			gras_pkg::OP_USED_NAT: begin
				occ_w = occ_r | pmask_q;
				nat_w = nat_r | pmask_q;
			end
			gras_pkg::OP_FREE_NAT: begin
				nat_w = nat_r & ~pmask_q;
				occ_w = (occ_r & ~pmask_q) | (blk_r & pmask_q);
			end
			gras_pkg::OP_USED_BLK: begin
				occ_w = occ_r | pmask_q;
				blk_w = blk_r | pmask_q;
			end
			gras_pkg::OP_FREE_BLK: begin
				blk_w = blk_r & ~pmask_q;
				occ_w = (occ_r & ~pmask_q) | (nat_r & pmask_q);
			end
			default: ;
		endcase
	end

	// vertical free runs and horizontal fit
	logic [HW-1:0]     h_n [GRID_W];
	logic [GRID_W-1:0] fit_col;
	logic [CW-1:0]     cnt_n;
	logic              window_full, last_row;
	logic [LW-1:0]     step;
	logic [GRID_W-1:0] acc_n, pow_n, cand;
	logic [LW-1:0]     l_n;
	logic [CW-1:0]     lo_idx, hi_idx, pick_x;
	logic              hit, better, row_major, l2r, t2b;

	always_comb begin
		row_major = fl_q[gras_pkg::FLAG_ROW_MAJOR];
		l2r = fl_q[gras_pkg::FLAG_L2R];
		t2b = fl_q[gras_pkg::FLAG_T2B];
		for (int c = 0; c < GRID_W; c++) begin
			h_n[c] = occ_r[c] ? '0 : run_q[c] + HW'(1);
			fit_col[c] = CW'(h_n[c]) >= CW'(ah_q);
		end
		cnt_n = cnt_q + CW'(1);
		window_full = cnt_n >= CW'(ah_q);
		last_row = rows_left_q == CW'(1);
		step = LW'(1) << k_q;
		acc_n = aw_q[k_q] ? (acc_q & (pow_q >> l_q)) : acc_q;
		l_n = aw_q[k_q] ? l_q + step : l_q;
		pow_n = pow_q & (pow_q >> step);
		cand = acc_q & xmask_q;
		hit = |cand;
		lo_idx = '0;
		hi_idx = '0;
		for (int c = GRID_W - 1; c >= 0; c--) begin
			if (cand[c]) lo_idx = CW'(c);
		end
		for (int c = 0; c < GRID_W; c++) begin
			if (cand[c]) hi_idx = CW'(c);
		end
		pick_x = l2r ? lo_idx : hi_idx;
		better = !res_ok_q || (l2r ? (pick_x < res_x_q) : (pick_x > res_x_q));
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			gras_pkg::ST_IDLE: begin
				if (start) state_n = gras_pkg::ST_SETUP;
			end
			gras_pkg::ST_SETUP: begin
				case (act_q)
					gras_pkg::ACT_FIND:
						state_n = find_bad ? gras_pkg::ST_DONE : gras_pkg::ST_FIND_RD;
					gras_pkg::ACT_MARK_USED, gras_pkg::ACT_MARK_FREE:
						state_n = gras_pkg::ST_PAINT_RD;
					gras_pkg::ACT_PLACE:
						state_n = (slot_free && w_q != '0) ? gras_pkg::ST_PAINT_RD :
							gras_pkg::ST_DONE;
					gras_pkg::ACT_LIFT:
						state_n = any_match ? gras_pkg::ST_PAINT_RD : gras_pkg::ST_DONE;
					default: state_n = gras_pkg::ST_DONE;
				endcase
			end
			gras_pkg::ST_PAINT_RD: begin
				if (pr_q < pend_q) state_n = gras_pkg::ST_PAINT_WR;
				else if (act_q == gras_pkg::ACT_LIFT) state_n = gras_pkg::ST_LIFT_NEXT;
				else state_n = gras_pkg::ST_DONE;
			end
			gras_pkg::ST_PAINT_WR: state_n = gras_pkg::ST_PAINT_RD;
			gras_pkg::ST_LIFT_NEXT: begin
				if (j_q == J_END) state_n = gras_pkg::ST_DONE;
				else if (lift_hit) state_n = gras_pkg::ST_PAINT_RD;
			end
			gras_pkg::ST_FIND_RD: state_n = gras_pkg::ST_FIND_ROW;
			gras_pkg::ST_FIND_ROW: begin
				if (window_full) state_n = gras_pkg::ST_FIND_FIT;
				else if (last_row) state_n = gras_pkg::ST_DONE;
				else state_n = gras_pkg::ST_FIND_RD;
			end
			gras_pkg::ST_FIND_FIT: begin
				if (k_q == K_LAST) state_n = gras_pkg::ST_FIND_PICK;
			end
			gras_pkg::ST_FIND_PICK: begin
				if ((hit && row_major) || last_row) state_n = gras_pkg::ST_DONE;
				else state_n = gras_pkg::ST_FIND_RD;
			end
			gras_pkg::ST_DONE: state_n = gras_pkg::ST_IDLE;
			default: state_n = gras_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = state_q != gras_pkg::ST_IDLE;
		done = state_q == gras_pkg::ST_DONE;
		ok = res_ok_q;
		found_x = res_x_q[gras_pkg::COORD_W-1:0];
		found_y = res_y_q[gras_pkg::COORD_W-1:0];
		raddr = (state_q == gras_pkg::ST_FIND_RD) ? r_q[YIW-1:0] : pr_q[YIW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gras_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// grid memory
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[raddr];
		if (state_q == gras_pkg::ST_PAINT_WR) begin
			mem[pr_q[YIW-1:0]] <= {blk_w, nat_w, occ_w};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_v_q <= '0;
			ovl_v_q <= '0;
			occ_vr_s1 <= 1'b0;
			ovl_vr_s1 <= 1'b0;
			for (int i = 0; i < MAX_BLOCKS; i++) ent_w_q[i] <= '0;
		end else begin
			occ_vr_s1 <= occ_v_q[raddr];
			ovl_vr_s1 <= ovl_v_q[raddr];
			if (state_q == gras_pkg::ST_PAINT_WR) begin
				occ_v_q[pr_q[YIW-1:0]] <= 1'b1;
				ovl_v_q[pr_q[YIW-1:0]] <= 1'b1;
			end
			if (state_q == gras_pkg::ST_SETUP) begin
				case (act_q)
					gras_pkg::ACT_CLR_OCC: occ_v_q <= '0;
					gras_pkg::ACT_CLR_OVL: begin
						ovl_v_q <= '0;
						for (int i = 0; i < MAX_BLOCKS; i++) ent_w_q[i] <= '0;
					end
					gras_pkg::ACT_PLACE: begin
						if (slot_free) ent_w_q[slot[JIW-1:0]] <= w_q;
					end
					gras_pkg::ACT_LIFT: begin
						for (int i = 0; i < MAX_BLOCKS; i++) begin
							if (match[i]) ent_w_q[i] <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// block list payload
	always_ff @(posedge clk) begin
		if (state_q == gras_pkg::ST_SETUP && act_q == gras_pkg::ACT_PLACE && slot_free) begin
			ent_x_q[slot[JIW-1:0]] <= x_q;
			ent_y_q[slot[JIW-1:0]] <= y_q;
			ent_h_q[slot[JIW-1:0]] <= h_q;
		end
	end

	// item capture, sweeps and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ok_q <= 1'b0;
			res_x_q <= '0;
			res_y_q <= '0;
		end else begin
			case (state_q)
				gras_pkg::ST_SETUP: begin
					res_ok_q <= (act_q == gras_pkg::ACT_PLACE) && slot_free;
					res_x_q <= '0;
					res_y_q <= '0;
				end
				gras_pkg::ST_FIND_PICK: begin
					if (hit && better) begin
						res_ok_q <= 1'b1;
						res_x_q <= pick_x;
						res_y_q <= top_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gras_pkg::ST_IDLE: begin
				act_q <= gras_pkg::action_t'(action);
				x_q <= rect_x;
				y_q <= rect_y;
				w_q <= rect_w;
				h_q <= rect_h;
				aw_q <= area_w;
				ah_q <= area_h;
				fl_q <= order_flags;
			end
			gras_pkg::ST_SETUP: begin
				pr_q <= y0;
				pend_q <= ey;
				pmask_q <= col_mask(x0, ex);
				j_q <= '0;
				case (act_q)
					gras_pkg::ACT_MARK_USED: pop_q <= gras_pkg::OP_USED_NAT;
					gras_pkg::ACT_MARK_FREE: pop_q <= gras_pkg::OP_FREE_NAT;
					gras_pkg::ACT_PLACE:     pop_q <= gras_pkg::OP_USED_BLK;
					default:                 pop_q <= gras_pkg::OP_FREE_BLK;
				endcase
				r_q <= t2b ? y0 : ey - CW'(1);
				rows_left_q <= bh;
				cnt_q <= '0;
				xmask_q <= col_mask(x0, ex - CW'(aw_q) + CW'(1));
				for (int c = 0; c < GRID_W; c++) run_q[c] <= '0;
			end
			gras_pkg::ST_PAINT_WR: pr_q <= pr_q + CW'(1);
			gras_pkg::ST_LIFT_NEXT: begin
				if (j_q != J_END) begin
					j_q <= j_q + JW'(1);
					pr_q <= cy0;
					pend_q <= cy1;
					pmask_q <= col_mask(cx0, cx1);
					pop_q <= gras_pkg::OP_USED_BLK;
				end
			end
			gras_pkg::ST_FIND_ROW: begin
				for (int c = 0; c < GRID_W; c++) run_q[c] <= h_n[c];
				cnt_q <= cnt_n;
				pow_q <= fit_col;
				acc_q <= '1;
				l_q <= '0;
				k_q <= '0;
				top_q <= t2b ? r_q - CW'(ah_q) + CW'(1) : r_q;
				// without a full window, step to the next row now
				if (!window_full) begin
					rows_left_q <= rows_left_q - CW'(1);
					r_q <= t2b ? r_q + CW'(1) : r_q - CW'(1);
				end
			end
			gras_pkg::ST_FIND_FIT: begin
				acc_q <= acc_n;
				pow_q <= pow_n;
				l_q <= l_n;
				k_q <= k_q + KW'(1);
			end
			gras_pkg::ST_FIND_PICK: begin
				rows_left_q <= rows_left_q - CW'(1);
				r_q <= t2b ? r_q + CW'(1) : r_q - CW'(1);
			end
			default: ;
		endcase
	end

	`GRAS_ASSERT(a_done_busy, done |-> busy, "done strobe outside a busy item")
	`GRAS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
	`GRAS_ASSERT(a_done_pulse, done |=> !done, "done strobe longer than one cycle")
	`GRAS_ASSERT(a_fail_zero, (done && !ok) |-> (found_x == '0 && found_y == '0),
		"failed result carries a position")
	`GRAS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !done, "done strobe right after reset")
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for grid_rectangle_space_allocator_core.
// Keeps its own copy of the grids and block list and predicts every result.
// Depends on gras_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
	localparam int GW = 128;
	localparam int GH = 128;
	localparam int NB = 16;
	localparam int N_RANDOM = 1450;

	typedef struct {
		logic [gras_pkg::ACT_W-1:0]   act;
		logic [gras_pkg::COORD_W-1:0] x, y;
		logic [gras_pkg::SIZE_W-1:0]  w, h, aw, ah;
		logic [gras_pkg::FLAG_W-1:0]  fl;
	} item_t;

	typedef struct {
		logic                         ok;
		logic [gras_pkg::COORD_W-1:0] fx, fy;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [gras_pkg::ACT_W-1:0] action = '0;
	logic [gras_pkg::COORD_W-1:0] rect_x = '0, rect_y = '0;
	logic [gras_pkg::SIZE_W-1:0] rect_w = '0, rect_h = '0, area_w = '0, area_h = '0;
	logic [gras_pkg::FLAG_W-1:0] order_flags = '0;
	wire busy, done, ok;
	wire [gras_pkg::COORD_W-1:0] found_x, found_y;

	grid_rectangle_space_allocator_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w),
		.rect_h(rect_h), .area_w(area_w), .area_h(area_h),
		.order_flags(order_flags), .done(done), .ok(ok),
		.found_x(found_x), .found_y(found_y)
	);

	bit occ_grid[GH][GW];
	bit nat_grid[GH][GW];
	bit blk_grid[GH][GW];
	int blk_x[NB], blk_y[NB], blk_w[NB], blk_h[NB];
	int sums[GH+1][GW+1];

	item_t   pending_items[$];
	result_t pending_results[$];
	item_t   cur_item;
	int      gap_left = 0;
	int      errors = 0;

	function automatic void clip(input int x, y, w, h, output int x0, y0, x1, y1);
		x1 = (x + w > GW) ? GW : x + w;
		y1 = (y + h > GH) ? GH : y + h;
		x0 = (x > x1) ? x1 : x;
		y0 = (y > y1) ? y1 : y;
	endfunction

	function automatic void paint_used(input int x, y, w, h, input bit on_blk);
		int x0, y0, x1, y1;
		clip(x, y, w, h, x0, y0, x1, y1);
		for (int i = y0; i < y1; i++)
			for (int j = x0; j < x1; j++) begin
				occ_grid[i][j] = 1;
				if (on_blk) blk_grid[i][j] = 1;
				else nat_grid[i][j] = 1;
			end
	endfunction

	// Clear one overlay; occupancy falls back to the other overlay.
	function automatic void paint_free(input int x, y, w, h, input bit on_blk);
		int x0, y0, x1, y1;
		clip(x, y, w, h, x0, y0, x1, y1);
		for (int i = y0; i < y1; i++)
			for (int j = x0; j < x1; j++) begin
				if (on_blk) begin
					occ_grid[i][j] = nat_grid[i][j];
					blk_grid[i][j] = 0;
				end else begin
					occ_grid[i][j] = blk_grid[i][j];
					nat_grid[i][j] = 0;
				end
			end
	endfunction

	function automatic bit first_fit(input item_t it, output int rx, ry);
		int bx, by, bx1, by1, bw, bh, aw, ah, nx, ny, a, b, tx, ty, s;
		bit rowmaj, l2r, t2b;
		clip(it.x, it.y, it.w, it.h, bx, by, bx1, by1);
		bw = bx1 - bx;
		bh = by1 - by;
		aw = it.aw;
		ah = it.ah;
		if (aw < 1 || ah < 1 || aw > bw || ah > bh) return 0;
		rowmaj = it.fl[gras_pkg::FLAG_ROW_MAJOR];
		l2r = it.fl[gras_pkg::FLAG_L2R];
		t2b = it.fl[gras_pkg::FLAG_T2B];
		for (int i = 0; i < GH; i++)
			for (int j = 0; j < GW; j++)
				sums[i+1][j+1] = occ_grid[i][j] + sums[i][j+1] + sums[i+1][j] - sums[i][j];
		nx = bw - aw + 1;
		ny = bh - ah + 1;
		for (int i = 0; i < (rowmaj ? ny : nx); i++)
			for (int j = 0; j < (rowmaj ? nx : ny); j++) begin
				a = rowmaj ? j : i;
				b = rowmaj ? i : j;
				tx = l2r ? bx + a : bx + bw - aw - a;
				ty = t2b ? by + b : by + bh - ah - b;
				s = sums[ty+ah][tx+aw] - sums[ty][tx+aw] - sums[ty+ah][tx] + sums[ty][tx];
				if (s == 0) begin
					rx = tx;
					ry = ty;
					return 1;
				end
			end
		return 0;
	endfunction

	function automatic void lift_block(input int x, y, w, h);
		int ix0, iy0, ix1, iy1;
		for (int i = 0; i < NB; i++) begin
			if (blk_w[i] == 0 || blk_x[i] != x || blk_y[i] != y || blk_w[i] != w
					|| blk_h[i] != h)
				continue;
			blk_w[i] = 0;
			paint_free(x, y, w, h, 1);
			// re-mark what other blocks still cover
			for (int j = 0; j < NB; j++) begin
				if (blk_w[j] == 0 || j == i) continue;
				ix0 = (blk_x[j] > x) ? blk_x[j] : x;
				iy0 = (blk_y[j] > y) ? blk_y[j] : y;
				ix1 = (x + w < blk_x[j] + blk_w[j]) ? x + w : blk_x[j] + blk_w[j];
				iy1 = (y + h < blk_y[j] + blk_h[j]) ? y + h : blk_y[j] + blk_h[j];
				if (ix1 > ix0 && iy1 > iy0) paint_used(ix0, iy0, ix1 - ix0, iy1 - iy0, 1);
			end
		end
	endfunction

	function automatic result_t apply_action(input item_t it);
		result_t r;
		int fx, fy;
		r = '{ok: 0, fx: '0, fy: '0};
		case (it.act)
			gras_pkg::ACT_FIND: if (first_fit(it, fx, fy)) begin
				r.ok = 1;
				r.fx = fx[gras_pkg::COORD_W-1:0];
				r.fy = fy[gras_pkg::COORD_W-1:0];
			end
			gras_pkg::ACT_MARK_USED: paint_used(it.x, it.y, it.w, it.h, 0);
			gras_pkg::ACT_MARK_FREE: paint_free(it.x, it.y, it.w, it.h, 0);
			gras_pkg::ACT_PLACE: for (int i = 0; i < NB; i++) if (blk_w[i] == 0) begin
				blk_x[i] = it.x;
				blk_y[i] = it.y;
				blk_w[i] = it.w;
				blk_h[i] = it.h;
				paint_used(it.x, it.y, it.w, it.h, 1);
				r.ok = 1;
				break;
			end
			gras_pkg::ACT_LIFT: lift_block(it.x, it.y, it.w, it.h);
			gras_pkg::ACT_CLR_OCC: foreach (occ_grid[i, j]) occ_grid[i][j] = 0;
			gras_pkg::ACT_CLR_OVL: begin
				foreach (nat_grid[i, j]) begin
					nat_grid[i][j] = 0;
					blk_grid[i][j] = 0;
				end
				foreach (blk_w[i]) begin
					blk_x[i] = 0; blk_y[i] = 0; blk_w[i] = 0; blk_h[i] = 0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 45) return 0;
		if (r < 88) return $urandom_range(3, 1);
		return $urandom_range(60, 4);
	endfunction

	function automatic item_t mk(input logic [gras_pkg::ACT_W-1:0] act, input int x, y, w, h,
			input int aw = 0, ah = 0, fl = 0);
		item_t it;
		it.act = act; it.x = x; it.y = y; it.w = w; it.h = h;
		it.aw = aw; it.ah = ah; it.fl = fl;
		return it;
	endfunction

	function automatic int rsize(input int hi);
		return ($urandom_range(19) == 0) ? $urandom_range(128) : $urandom_range(hi);
	endfunction

	initial forever #5 clk = ~clk;

	// driver: accept on start && !busy, predict at acceptance
	always @(posedge clk or negedge arst_n) begin
		bit launch;
		result_t r;
		int g;
		launch = 0;
		if (!arst_n) begin
			start <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				r = apply_action(cur_item);
				pending_results.push_back(r);
				g = pick_gap();
				if (g == 0 && pending_items.size() > 0) launch = 1;
				else begin
					start <= 0;
					gap_left <= g;
				end
			end else if (!start && pending_items.size() > 0) begin
				if (gap_left == 0) launch = 1;
				else gap_left <= gap_left - 1;
			end
			if (launch) begin
				cur_item = pending_items.pop_front();
				start <= 1;
				action <= cur_item.act;
				rect_x <= cur_item.x;
				rect_y <= cur_item.y;
				rect_w <= cur_item.w;
				rect_h <= cur_item.h;
				area_w <= cur_item.aw;
				area_h <= cur_item.ah;
				order_flags <= cur_item.fl;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result ok=%0b x=%0d y=%0d", $time, ok, found_x,
					found_y);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (ok !== e.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, e.ok, ok);
					errors++;
				end
				if (found_x !== e.fx) begin
					$display("%0t: found_x expected %0d actual %0d", $time, e.fx, found_x);
					errors++;
				end
				if (found_y !== e.fy) begin
					$display("%0t: found_y expected %0d actual %0d", $time, e.fy, found_y);
					errors++;
				end
			end
		end
	end

	initial begin
		item_t placed[$];
		item_t it;
		int r, k;
		// directed: extremes, every action, every scan order, clipping, full list
		pending_items.push_back(mk(gras_pkg::ACT_FIND, 0, 0, 128, 128, 128, 128, 7));
		pending_items.push_back(mk(gras_pkg::ACT_FIND, 127, 127, 128, 128, 1, 1, 0));
		pending_items.push_back(mk(gras_pkg::ACT_FIND, 0, 0, 128, 128, 0, 4, 7));
		pending_items.push_back(mk(gras_pkg::ACT_FIND, 0, 0, 128, 128, 4, 0, 7));
		pending_items.push_back(mk(gras_pkg::ACT_FIND, 120, 0, 128, 10, 9, 2, 7));
		pending_items.push_back(mk(gras_pkg::ACT_MARK_USED, 127, 127, 128, 128));
		pending_items.push_back(mk(gras_pkg::ACT_MARK_USED, 0, 0, 128, 1));
		pending_items.push_back(mk(gras_pkg::ACT_MARK_USED, 60, 60, 0, 20));
		pending_items.push_back(mk(gras_pkg::ACT_MARK_USED, 40, 40, 10, 10));
		for (int f = 0; f < 8; f++)
			pending_items.push_back(mk(gras_pkg::ACT_FIND, 30, 30, 40, 40, 6, 5, f));
		pending_items.push_back(mk(gras_pkg::ACT_FIND, 1, 1, 127, 127, 127, 127, 6));
		pending_items.push_back(mk(gras_pkg::ACT_PLACE, 0, 0, 0, 5));
		for (int i = 0; i < NB + 1; i++)
			pending_items.push_back(mk(gras_pkg::ACT_PLACE, 40 + i, 45, 8, 8));
		pending_items.push_back(mk(gras_pkg::ACT_PLACE, 40, 45, 8, 8));
		pending_items.push_back(mk(gras_pkg::ACT_LIFT, 41, 45, 8, 8));
		pending_items.push_back(mk(gras_pkg::ACT_PLACE, 41, 45, 8, 8));
		pending_items.push_back(mk(gras_pkg::ACT_LIFT, 41, 45, 8, 8));
		pending_items.push_back(mk(gras_pkg::ACT_MARK_FREE, 0, 0, 128, 128));
		pending_items.push_back(mk(gras_pkg::ACT_FIND, 0, 0, 128, 128, 30, 30, 1));
		pending_items.push_back(mk(7, 1, 1, 5, 5, 1, 1, 7));
		pending_items.push_back(mk(gras_pkg::ACT_CLR_OVL, 0, 0, 0, 0));
		pending_items.push_back(mk(gras_pkg::ACT_CLR_OCC, 0, 0, 0, 0));

		for (int n = 0; n < N_RANDOM; n++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				it = mk(gras_pkg::ACT_FIND, $urandom_range(127), $urandom_range(127),
					rsize(24), rsize(24), $urandom_range(8), $urandom_range(8),
					$urandom_range(7));
				if ($urandom_range(9) == 0) begin
					it.aw = $urandom_range(128);
					it.ah = $urandom_range(128);
				end
			end else if (r < 55)
				it = mk(gras_pkg::ACT_MARK_USED, $urandom_range(127), $urandom_range(127),
					rsize(14), rsize(14));
			else if (r < 66)
				it = mk(gras_pkg::ACT_MARK_FREE, $urandom_range(127), $urandom_range(127),
					rsize(30), rsize(30));
			else if (r < 79) begin
				it = mk(gras_pkg::ACT_PLACE, $urandom_range(127), $urandom_range(127),
					rsize(16), rsize(16));
				placed.push_back(it);
				if (placed.size() > 40) void'(placed.pop_front());
			end else if (r < 92) begin
				if (placed.size() > 0 && $urandom_range(9) != 0) begin
					k = $urandom_range(placed.size() - 1);
					it = placed[k];
					it.act = gras_pkg::ACT_LIFT;
					placed.delete(k);
				end else
					it = mk(gras_pkg::ACT_LIFT, $urandom_range(127), $urandom_range(127),
						rsize(16), rsize(16));
			end else if (r < 95)
				it = mk(gras_pkg::ACT_CLR_OCC, $urandom_range(127), $urandom_range(127), 0, 0);
			else if (r < 98) begin
				it = mk(gras_pkg::ACT_CLR_OVL, 0, 0, $urandom_range(128), 0);
				placed.delete();
			end else
				it = mk(7, $urandom_range(127), $urandom_range(127), 4, 4, 1, 1, 0);
			if (it.act != gras_pkg::ACT_FIND) begin
				it.aw = $urandom_range(128);
				it.ah = $urandom_range(128);
				it.fl = $urandom_range(7);
			end
			pending_items.push_back(it);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1;
		while (pending_items.size() > 0 || start || pending_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1_000_000_000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/gras_pkg.sv
rtl/grid_rectangle_space_allocator_core.sv
verif/tb.sv
